FILE: rtl/core/sorted_edge_segment_index_defines.svh
// ----------------------------------------------------------------------------
// sorted edge segment index assertion macros
// shared concurrent assertion forms for the block checker
// ----------------------------------------------------------------------------
`ifndef SORTED_EDGE_SEGMENT_INDEX_DEFINES_SVH
`define SORTED_EDGE_SEGMENT_INDEX_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SESI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SESI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/sesi_pkg.sv
// ----------------------------------------------------------------------------
// sesi_pkg
// shared constants and control/status types of the segment index block
// ----------------------------------------------------------------------------
`default_nettype none

package sesi_pkg;

    localparam int INDEX_WIDTH = 11;
    localparam int TOL_WIDTH   = 31;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // register index as seen on paddr[2]
    localparam logic REG_TOLERANCE = 1'b0;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic in_ready;
        logic load_write;
        logic query_start;
        logic rd_pos;
        logic rd_next;
        logic rd_prev;
        logic step;
        logic snap_apply;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic item_valid;
        logic item_query;
        logic pos_lt_count;
        logic next_lt_count;
        logic pos_nonzero;
        logic lt_key;
        logic snap_hit;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/sesi_stream_if.sv
// ----------------------------------------------------------------------------
// sesi stream interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface sesi_item_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic                          first;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output cmd, output first, output value, input ready);
    modport sink   (input valid, input cmd, input first, input value, output ready);
endinterface

interface sesi_result_if;
    logic                               valid;
    logic                               ready;
    logic [sesi_pkg::INDEX_WIDTH-1:0]   segment_index;

    modport source (output valid, output segment_index, input ready);
    modport sink   (input valid, input segment_index, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sorted_edge_segment_index.sv
// A load item appends one point to the on-chip point store (writes past
// POINT_DEPTH are dropped). A query item steps through accept, a first
// read, one compare per point read from the single-port point RAM, one
// extra read of the point before the stop position for the tolerance snap,
// and the hand-off to the output register (fewer steps when the list is
// empty or nothing lies before the stop position). The input is stalled
// while a query runs. Since each query resumes where the last one stopped,
// a run of ascending edges passes each stored point about once in total.
// A finished index waits in an output register, so new items are taken while
// it waits; a second finished query holds until that register frees up.
// ----------------------------------------------------------------------------
// sorted_edge_segment_index
// merge-style lower-bound search of bin edges over a stored ascending list
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_edge_segment_index #(
    parameter int POINT_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    sesi_item_if.sink                          item,
    sesi_result_if.source                      result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [sesi_pkg::APB_AW-1:0]   paddr,
    input  wire logic [sesi_pkg::APB_DW-1:0]   pwdata,
    output logic      [sesi_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    sesi_pkg::ctrl_cmd_t           cmd;
    sesi_pkg::dp_status_t          status;
    logic [sesi_pkg::TOL_WIDTH-1:0] tolerance_reg;
    logic                           tol_write;

    assign pready    = 1'b1;
    assign tol_write = psel && penable && pwrite && (paddr[2] == sesi_pkg::REG_TOLERANCE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= '0;
        end
        else if (tol_write)
        begin
            tolerance_reg <= pwdata[sesi_pkg::TOL_WIDTH-1:0];
        end
    end

    assign prdata = (paddr[2] == sesi_pkg::REG_TOLERANCE)
                  ? sesi_pkg::APB_DW'(tolerance_reg) : '0;

    sesi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sesi_datapath #(
        .POINT_DEPTH (POINT_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .item_valid   (item.valid),
        .item_cmd     (item.cmd),
        .item_first   (item.first),
        .item_value   (item.value),
        .tolerance    (tolerance_reg),
        .result_ready (result.ready),
        .result_valid (result.valid),
        .result_index (result.segment_index),
        .status       (status)
    );

    assign item.ready = cmd.in_ready;

endmodule

`default_nettype wire

FILE: rtl/core/sesi_ram.sv
// ----------------------------------------------------------------------------
// sesi_ram
// single-port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sesi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/sesi_ctrl.sv
// ----------------------------------------------------------------------------
// sesi_ctrl
// sequencer for load, forward walk, tolerance snap and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module sesi_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sesi_pkg::dp_status_t status,
    output sesi_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_SNAP  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.item_valid)
                begin
                    if (status.item_query == sesi_pkg::CMD_QUERY)
                    begin
                        cmd.query_start = 1'b1;
                        state_next      = ST_FETCH;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                if (status.pos_lt_count)
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = ST_WALK;
                end
                else if (status.pos_nonzero)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_SNAP;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_WALK:
            begin
                if (status.lt_key)
                begin
                    cmd.step = 1'b1;
                    if (status.next_lt_count)
                    begin
                        // read the next point while stepping
                        cmd.rd_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
                else if (status.pos_nonzero)
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_SNAP;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SNAP:
            begin
                cmd.snap_apply = status.snap_hit;
                state_next     = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/sesi_datapath.sv
// ----------------------------------------------------------------------------
// sesi_datapath
// point store, count, search pointer, key compare and result register
// ----------------------------------------------------------------------------
`default_nettype none

module sesi_datapath #(
    parameter int POINT_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sesi_pkg::ctrl_cmd_t                 cmd,
    input  wire logic                                item_valid,
    input  wire logic                                item_cmd,
    input  wire logic                                item_first,
    input  wire logic signed [VALUE_WIDTH-1:0]       item_value,
    input  wire logic [sesi_pkg::TOL_WIDTH-1:0]      tolerance,
    input  wire logic                                result_ready,
    output logic                                     result_valid,
    output logic      [sesi_pkg::INDEX_WIDTH-1:0]    result_index,
    output sesi_pkg::dp_status_t                     status
);

    localparam int AW    = $clog2(POINT_DEPTH);
    localparam int CW    = $clog2(POINT_DEPTH + 1);
    localparam int DW    = VALUE_WIDTH + 1;
    localparam int CMP_W = (DW > sesi_pkg::TOL_WIDTH) ? DW : sesi_pkg::TOL_WIDTH;

    logic [CW-1:0]                    count_reg,  count_next;
    logic [CW-1:0]                    search_reg, search_next;
    logic [CW-1:0]                    pos_reg,    pos_next;
    logic signed [VALUE_WIDTH-1:0]    key_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [sesi_pkg::INDEX_WIDTH-1:0] out_index_reg;

    logic                             ram_we;
    logic                             ram_re;
    logic [AW-1:0]                    ram_addr;
    logic [VALUE_WIDTH-1:0]           ram_rdata;

    logic [CW-1:0]                    pos_plus;
    logic [CW-1:0]                    pos_minus;
    logic                             store_full;
    logic [CW-1:0]                    search_clamped;
    logic signed [DW-1:0]             diff;
    logic [DW-1:0]                    abs_diff;

    sesi_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (POINT_DEPTH)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (item_value),
        .rdata (ram_rdata)
    );

    assign pos_plus       = pos_reg + CW'(1);
    assign pos_minus      = pos_reg - CW'(1);
    assign store_full     = (count_reg >= CW'(POINT_DEPTH));
    assign search_clamped = (search_reg > count_reg) ? count_reg : search_reg;

    assign ram_we = cmd.load_write && (item_first || !store_full);
    assign ram_re = cmd.rd_pos || cmd.rd_next || cmd.rd_prev;

    always_comb
    begin
        ram_addr = pos_reg[AW-1:0];
        if (cmd.load_write)
        begin
            ram_addr = item_first ? '0 : count_reg[AW-1:0];
        end
        else if (cmd.rd_next)
        begin
            ram_addr = pos_plus[AW-1:0];
        end
        else if (cmd.rd_prev)
        begin
            ram_addr = pos_minus[AW-1:0];
        end
    end

    // exact distance between the previous point and the edge
    assign diff     = DW'($signed(ram_rdata)) - DW'(key_reg);
    assign abs_diff = diff[DW-1] ? DW'(-diff) : DW'(diff);

    always_comb
    begin
        count_next     = count_reg;
        search_next    = search_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_write)
        begin
            if (item_first)
            begin
                count_next  = CW'(1);
                search_next = '0;
            end
            else if (!store_full)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        if (cmd.query_start)
        begin
            pos_next = item_first ? '0 : search_clamped;
        end
        if (cmd.step)
        begin
            pos_next = pos_plus;
        end
        if (cmd.snap_apply)
        begin
            pos_next = pos_minus;
        end
        if (cmd.out_load)
        begin
            search_next    = pos_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            search_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            search_reg    <= search_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.query_start)
        begin
            key_reg <= item_value;
        end
        if (cmd.out_load)
        begin
            out_index_reg <= sesi_pkg::INDEX_WIDTH'(pos_reg);
        end
    end

    assign status.item_valid    = item_valid;
    assign status.item_query    = item_cmd;
    assign status.pos_lt_count  = (pos_reg < count_reg);
    assign status.next_lt_count = (pos_plus < count_reg);
    assign status.pos_nonzero   = (pos_reg != '0);
    assign status.lt_key        = ($signed(ram_rdata) < key_reg);
    assign status.snap_hit      = (CMP_W'(abs_diff) < CMP_W'(tolerance));
    assign status.out_free      = !out_valid_reg || result_ready;

    assign result_valid = out_valid_reg;
    assign result_index = out_index_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sesi_checker.sv
// ----------------------------------------------------------------------------
// sesi_checker
// port-level checks of transaction ordering for the segment index block
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_edge_segment_index_defines.svh"

module sesi_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic item_valid,
    input wire logic item_ready,
    input wire logic item_cmd,
    input wire logic result_valid,
    input wire logic result_ready
);

    logic [1:0] pending_reg;
    logic       query_acc;
    logic       load_acc;
    logic       result_acc;

    assign query_acc  = item_valid && item_ready && (item_cmd == sesi_pkg::CMD_QUERY);
    assign load_acc   = item_valid && item_ready && (item_cmd == sesi_pkg::CMD_LOAD);
    assign result_acc = result_valid && result_ready;

    // queries accepted whose result transaction has not completed yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (query_acc && !result_acc)
        begin
            pending_reg <= pending_reg + 2'd1;
        end
        else if (result_acc && !query_acc)
        begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    `SESI_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `SESI_ASSERT_IMP(a_result_owed, clk, rst_n, result_valid, pending_reg != 2'd0, "result without an outstanding query")
    `SESI_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, pending_reg != 2'd3, "more than two queries outstanding or a spurious result")
    `SESI_ASSERT_NXT(a_load_ready, clk, rst_n, load_acc, item_ready, "block not ready after a load")

endmodule

bind sorted_edge_segment_index sesi_checker u_sesi_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_cmd     (item.cmd),
    .result_valid (result.valid),
    .result_ready (result.ready)
);

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// sorted edge segment index testbench
// loads ascending point lists, sweeps bin edges over them and checks every
// returned segment index against a cycle-free model of the search, under
// random source gaps, sink stalls and several snap tolerance settings
// ----------------------------------------------------------------------------
module testbench;

    localparam int POINT_DEPTH    = 1024;
    localparam int VALUE_WIDTH    = 32;
    localparam int RANDOM_ITEMS   = 800;
    localparam int SETTLE_CYCLES  = 16;
    localparam int HOLD_CYCLES    = 500;
    localparam int HOLD_AFTER     = 60;
    localparam int WATCHDOG_LIMIT = 8000;

    localparam logic [sesi_pkg::APB_AW-1:0] TOLERANCE_ADDR = {sesi_pkg::REG_TOLERANCE, 2'b00};
    localparam logic [sesi_pkg::TOL_WIDTH-1:0] TOL_MAX = '1;
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                          cmd;
        logic                          first;
        logic signed [VALUE_WIDTH-1:0] value;
    } edge_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [sesi_pkg::APB_AW-1:0]   paddr = '0;
    logic [sesi_pkg::APB_DW-1:0]   pwdata = '0;
    wire  [sesi_pkg::APB_DW-1:0]   prdata;
    wire                           pready;

    logic                          drv_valid = 1'b0;
    logic                          drv_cmd = sesi_pkg::CMD_LOAD;
    logic                          drv_first = 1'b0;
    logic signed [VALUE_WIDTH-1:0] drv_value = '0;
    logic                          drv_ready = 1'b0;

    sesi_item_if #(.VALUE_WIDTH(VALUE_WIDTH)) item_ch ();
    sesi_result_if result_ch ();

    assign item_ch.valid   = drv_valid;
    assign item_ch.cmd     = drv_cmd;
    assign item_ch.first   = drv_first;
    assign item_ch.value   = drv_value;
    assign result_ch.ready = drv_ready;

    sorted_edge_segment_index #(
        .POINT_DEPTH(POINT_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // search model state
    logic signed [VALUE_WIDTH-1:0]    point_copy [POINT_DEPTH];
    int                               point_total = 0;
    int                               walk_pos = 0;
    logic [sesi_pkg::TOL_WIDTH-1:0]   snap_tol = '0;

    edge_item_t                         pending_items [$];
    logic [sesi_pkg::INDEX_WIDTH-1:0]   expected_index [$];

    int  fail_count = 0;
    int  stim_count = 0;
    int  results_seen = 0;
    int  stall_cycles = 0;
    bit  item_fire = 1'b0;
    bit  result_fire = 1'b0;
    logic [sesi_pkg::INDEX_WIDTH-1:0] predicted;
    logic [sesi_pkg::INDEX_WIDTH-1:0] oldest;

    // source burst state
    int         burst_left = 0;
    int         gap_left = 0;
    edge_item_t next_item;

    // sink stall state
    int hold_left = 0;
    bit hold_done = 1'b0;
    int rx_cycle = 0;
    int rx_mode = 0;
    bit rx_ready;

    // span of the most recently queued point list
    longint list_lo = 0;
    longint list_hi = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit search_segment(input logic cmd, input logic first,
                                          input logic signed [VALUE_WIDTH-1:0] val,
                                          output logic [sesi_pkg::INDEX_WIDTH-1:0] idx);
        int     p;
        longint span;
        idx = '0;
        if (cmd == sesi_pkg::CMD_LOAD)
        begin
            // a restarted list also invalidates the search position
            if (first)
            begin
                point_total = 0;
                walk_pos = 0;
            end
            if (point_total < POINT_DEPTH)
            begin
                point_copy[point_total] = val;
                point_total++;
            end
            return 1'b0;
        end
        if (first)
            walk_pos = 0;
        p = (walk_pos > point_total) ? point_total : walk_pos;
        while (p < point_total && point_copy[p] < val)
            p++;
        if (p > 0)
        begin
            span = longint'(point_copy[p-1]) - longint'(val);
            if (span < 0)
                span = -span;
            if (span < longint'(snap_tol))
                p--;
        end
        walk_pos = p;
        idx = p[sesi_pkg::INDEX_WIDTH-1:0];
        return 1'b1;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] to_value(input longint v);
        if (v > longint'(VALUE_MAX))
            return VALUE_MAX;
        if (v < longint'(VALUE_MIN))
            return VALUE_MIN;
        return v[VALUE_WIDTH-1:0];
    endfunction

    task automatic push_item(input logic cmd, input logic first,
                             input logic signed [VALUE_WIDTH-1:0] val);
        edge_item_t it;
        it.cmd = cmd;
        it.first = first;
        it.value = val;
        pending_items.push_back(it);
        stim_count++;
    endtask

    task automatic wait_idle();
        do
        begin
            while (pending_items.size() != 0 || drv_valid || expected_index.size() != 0)
                @(negedge clk);
            // loads give no result, so let the last one settle
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
        while (pending_items.size() != 0 || drv_valid || expected_index.size() != 0);
    endtask

    task automatic set_tolerance(input logic [sesi_pkg::TOL_WIDTH-1:0] tol);
        wait_idle();
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = TOLERANCE_ADDR;
        pwdata = {1'($urandom_range(0, 1)), tol};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        snap_tol = tol;
    endtask

    task automatic queue_point_list(input int n, input longint start,
                                    input int unsigned step_max);
        longint v;
        v = start;
        list_lo = start;
        for (int i = 0; i < n; i++)
        begin
            push_item(sesi_pkg::CMD_LOAD, i == 0, to_value(v));
            list_hi = v;
            v += longint'($urandom_range(0, step_max));
        end
    endtask

    task automatic queue_edge_sweep(input int m, input longint lo, input longint hi);
        longint      step;
        int unsigned step_u;
        longint      e;
        step = (hi - lo + 1) * 2 / m + 1;
        step_u = (step > 64'sh7FFF_FFFF) ? 32'h7FFF_FFFF : int'(step);
        e = lo - longint'($urandom_range(0, step_u));
        for (int j = 0; j < m; j++)
        begin
            if ($urandom_range(0, 9) == 0)
                push_item(sesi_pkg::CMD_QUERY, 1'($urandom_range(0, 1)), $urandom);
            else if ($urandom_range(0, 19) == 0)
                push_item(sesi_pkg::CMD_LOAD, 1'b0, to_value(e));
            else
                push_item(sesi_pkg::CMD_QUERY, j == 0, to_value(e));
            e += longint'($urandom_range(0, step_u));
        end
    endtask

    // monitor and scoreboard
    always @(posedge clk)
    begin
        item_fire = rst_n && item_ch.valid && item_ch.ready;
        result_fire = rst_n && result_ch.valid && result_ch.ready;
        if (item_fire)
        begin
            if (search_segment(item_ch.cmd, item_ch.first, item_ch.value, predicted))
                expected_index.push_back(predicted);
        end
        if (result_fire)
        begin
            results_seen++;
            if (expected_index.size() == 0)
            begin
                $error("segment_index: expected none, actual %0d", result_ch.segment_index);
                fail_count++;
            end
            else
            begin
                oldest = expected_index.pop_front();
                if (oldest !== result_ch.segment_index)
                begin
                    $error("segment_index: expected %0d, actual %0d",
                           oldest, result_ch.segment_index);
                    fail_count++;
                end
            end
        end
        if (item_fire || result_fire)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // source: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!drv_valid || item_fire))
        begin
            if (gap_left == 0 && pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                drv_valid <= 1'b1;
                drv_cmd <= next_item.cmd;
                drv_first <= next_item.first;
                drv_value <= next_item.value;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                if (gap_left > 0)
                    gap_left--;
                drv_valid <= 1'b0;
            end
        end
    end

    // sink: a randomly redrawn stall pattern from four modes, plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_cycle % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            rx_cycle++;
            if (hold_left > 0)
            begin
                hold_left--;
                rx_ready = 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rx_ready = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: rx_ready = 1'b1;
                    1: rx_ready = 1'($urandom_range(0, 1));
                    2: rx_ready = ($urandom_range(0, 3) == 0);
                    default: rx_ready = (rx_cycle % 7) < 3;
                endcase
            end
            drv_ready <= rx_ready;
        end
    end

    initial
    begin
        int          n;
        int          phase;
        int unsigned step_max;
        longint      start;
        logic [sesi_pkg::TOL_WIDTH-1:0] tol;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty list, field extremes, duplicates, stale position
        set_tolerance('0);
        push_item(sesi_pkg::CMD_QUERY, 1'b0, 32'sd0);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, VALUE_MIN);
        push_item(sesi_pkg::CMD_LOAD, 1'b1, VALUE_MIN);
        push_item(sesi_pkg::CMD_LOAD, 1'b0, -32'sd65536);
        push_item(sesi_pkg::CMD_LOAD, 1'b0, 32'sd0);
        push_item(sesi_pkg::CMD_LOAD, 1'b0, 32'sd0);
        push_item(sesi_pkg::CMD_LOAD, 1'b0, 32'sd65536);
        push_item(sesi_pkg::CMD_LOAD, 1'b0, VALUE_MAX);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, VALUE_MIN);
        push_item(sesi_pkg::CMD_QUERY, 1'b0, 32'sd0);
        push_item(sesi_pkg::CMD_QUERY, 1'b0, 32'sd32768);
        push_item(sesi_pkg::CMD_QUERY, 1'b0, VALUE_MAX);
        push_item(sesi_pkg::CMD_QUERY, 1'b0, -32'sd65536);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, 32'sd1);
        // unsorted append, then walk past it
        push_item(sesi_pkg::CMD_LOAD, 1'b0, -32'sd100);
        push_item(sesi_pkg::CMD_QUERY, 1'b0, VALUE_MAX);

        // no snap inside the list, a snap at the end, and none at exactly the tolerance
        set_tolerance(31'h0001_0000);
        push_item(sesi_pkg::CMD_LOAD, 1'b1, 32'sd0);
        push_item(sesi_pkg::CMD_LOAD, 1'b0, 32'sh0002_0000);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, 32'sh0001_8000);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, 32'sh0002_8000);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, 32'sh0003_0000);

        // widest tolerance, and a distance that would wrap in 32 bits
        set_tolerance(TOL_MAX);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, VALUE_MAX);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, VALUE_MIN);
        push_item(sesi_pkg::CMD_LOAD, 1'b1, VALUE_MIN);
        push_item(sesi_pkg::CMD_QUERY, 1'b1, VALUE_MAX);

        // fill the store past its depth, then sweep the whole list
        set_tolerance(31'($urandom_range(0, 32'h0008_0000)));
        queue_point_list(POINT_DEPTH + 6, longint'($signed($urandom_range(0, 32'h00FF_FFFF))),
                         32'h0010_0000);
        queue_edge_sweep(20, list_lo, list_hi);

        stim_count = 0;
        phase = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            phase++;
            case ($urandom_range(0, 4))
                0: step_max = 0;
                1: step_max = 32'h0000_0100;
                2: step_max = 32'h0001_0000;
                3: step_max = 32'h0100_0000;
                default: step_max = 32'h1000_0000;
            endcase
            if (phase % 6 == 1)
                tol = TOL_MAX;
            else if (phase % 6 == 2)
                tol = '0;
            else if ($urandom_range(0, 1) == 0)
                tol = 31'($urandom_range(0, 2 * step_max + 1));
            else
                tol = 31'($urandom);
            set_tolerance(tol);

            if ($urandom_range(0, 4) == 0)
            begin
                // noise: any command, any value, occasional restarts
                n = $urandom_range(10, 40);
                for (int k = 0; k < n; k++)
                    push_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, $urandom);
            end
            else
            begin
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
                if ($urandom_range(0, 4) == 0)
                    start = longint'($signed($urandom));
                else
                    start = longint'($urandom_range(0, 32'h0200_0000)) - 64'sh0100_0000;
                if (n > 0)
                    queue_point_list(n, start, step_max);
                queue_edge_sweep($urandom_range(1, 30), list_lo, list_hi);
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
